>>> hw/rtl/cvks_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvks_pkg
// Shared types, constants and commands for the constant-velocity smoother.
// ----------------------------------------------------------------------------
package cvks_pkg;

   localparam int COORD_FRAC_BITS = 16;
   localparam int COV_FRAC        = 24;
   localparam int DIV_STEPS       = 33;
   localparam int CNT_W           = 6;
   localparam logic [32:0] GAIN_ONE = 33'h1_0000_00;

   localparam logic [1:0] REG_PROCESS_NOISE      = 2'd0;
   localparam logic [1:0] REG_MEASUREMENT_NOISE  = 2'd1;
   localparam logic [1:0] REG_INITIAL_COVARIANCE = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREDICT,
      ST_DIV_KP_START,
      ST_DIV_KP,
      ST_DIV_KV_START,
      ST_DIV_KV,
      ST_MUL_X,
      ST_MUL_Y,
      ST_UPDATE,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic load;
      logic init;
      logic predict;
      logic div_start_kp;
      logic div_start_kv;
      logic div_step;
      logic take_kp;
      logic take_kv;
      logic mul_x;
      logic mul_y;
      logic update;
   } cmd_type;

   typedef struct packed {
      logic first;
      logic div_done;
   } status_type;

endpackage

>>> hw/rtl/cvks_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvks_ctrl
// Sequencer for predict, gain division, correction and result hand-off.
// ----------------------------------------------------------------------------
module cvks_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   output logic                   out_valid,
   input  logic                   out_ready,
   input  cvks_pkg::status_type   status,
   output cvks_pkg::cmd_type      cmd
);

   cvks_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cvks_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      in_ready  = 1'b0;
      out_valid = 1'b0;
      case (state_ff)
         cvks_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = cvks_pkg::ST_PREDICT;
            end
         end
         cvks_pkg::ST_PREDICT: begin
            if (status.first) begin
               cmd.init = 1'b1;
               state_in = cvks_pkg::ST_IDLE;
            end else begin
               cmd.predict = 1'b1;
               state_in    = cvks_pkg::ST_DIV_KP_START;
            end
         end
         cvks_pkg::ST_DIV_KP_START: begin
            cmd.div_start_kp = 1'b1;
            state_in         = cvks_pkg::ST_DIV_KP;
         end
         cvks_pkg::ST_DIV_KP: begin
            if (status.div_done) begin
               cmd.take_kp = 1'b1;
               state_in    = cvks_pkg::ST_DIV_KV_START;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         cvks_pkg::ST_DIV_KV_START: begin
            cmd.div_start_kv = 1'b1;
            state_in         = cvks_pkg::ST_DIV_KV;
         end
         cvks_pkg::ST_DIV_KV: begin
            if (status.div_done) begin
               cmd.take_kv = 1'b1;
               state_in    = cvks_pkg::ST_MUL_X;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         cvks_pkg::ST_MUL_X: begin
            cmd.mul_x = 1'b1;
            state_in  = cvks_pkg::ST_MUL_Y;
         end
         cvks_pkg::ST_MUL_Y: begin
            cmd.mul_y = 1'b1;
            state_in  = cvks_pkg::ST_UPDATE;
         end
         cvks_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = cvks_pkg::ST_OUTPUT;
         end
         cvks_pkg::ST_OUTPUT: begin
            out_valid = 1'b1;
            if (out_ready) begin
               state_in = cvks_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cvks_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> hw/rtl/cvks_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvks_dp
// Filter state, predict terms, restoring gain divider and correction math.
// ----------------------------------------------------------------------------
module cvks_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  cvks_pkg::cmd_type      cmd,
   output cvks_pkg::status_type   status,
   input  logic [31:0]            process_noise,
   input  logic [31:0]            measurement_noise,
   input  logic [31:0]            initial_covariance,
   input  logic signed [31:0]     meas_x,
   input  logic signed [31:0]     meas_y,
   input  logic signed [31:0]     depth_z,
   input  logic                   first_point,
   output logic signed [31:0]     est_x,
   output logic signed [31:0]     est_y,
   output logic signed [31:0]     out_z
);

   logic signed [31:0] mx_ff, my_ff, mz_ff;
   logic               first_ff;
   logic signed [31:0] pos_x_ff, pos_y_ff, vel_x_ff, vel_y_ff;
   logic signed [31:0] pos_x_in, pos_y_in, vel_x_in, vel_y_in;
   logic [31:0]        cpp_ff, cpv_ff, cvv_ff;
   logic [31:0]        cpp_in, cpv_in, cvv_in;
   logic [31:0]        ppp_ff, ppv_ff, pvv_ff;
   logic signed [31:0] prx_ff, pry_ff;
   logic [32:0]        s_ff;
   logic [31:0]        kp_ff, kv_ff;
   logic [56:0]        num_ff;
   logic [33:0]        rem_ff;
   logic [32:0]        quo_ff;
   logic               ovf_ff;
   logic [cvks_pkg::CNT_W-1:0] cnt_ff;
   logic signed [33:0] dpx_ff, dvx_ff, dpy_ff, dvy_ff;

   function automatic logic [31:0] sat_u32(input logic [34:0] v);
      sat_u32 = (v[34:32] != 3'd0) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   function automatic logic signed [31:0] sat_s32(input logic signed [34:0] v);
      if (v > 35'sh0_7FFF_FFFF) begin
         sat_s32 = 32'sh7FFF_FFFF;
      end else if (v < -35'sh0_8000_0000) begin
         sat_s32 = -32'sh8000_0000;
      end else begin
         sat_s32 = v[31:0];
      end
   endfunction

   function automatic logic signed [33:0] mul_sgn(input logic [31:0] k,
                                                   input logic signed [32:0] e);
      logic [32:0] mag;
      logic [64:0] prod;
      logic [33:0] r;
      mag  = e[32] ? 33'(-e) : 33'(e);
      prod = 65'(k) * 65'(mag) + 65'(cvks_pkg::GAIN_ONE >> 1);
      r    = prod[57:24];
      mul_sgn = e[32] ? -$signed(r) : $signed(r);
   endfunction

   function automatic logic [31:0] mul_cov(input logic [31:0] k, input logic [31:0] c);
      logic [63:0] prod;
      prod = 64'(k) * 64'(c) + 64'(cvks_pkg::GAIN_ONE >> 1);
      mul_cov = prod[55:24];
   endfunction

   logic [33:0] trial;
   logic [32:0] qfix;
   logic [31:0] kres;
   logic [31:0] dec_cpp, dec_cpv, dec_cvv;
   logic [32:0] div_s;
   logic [56:0] div_num;

   always_comb begin
      trial   = {rem_ff[32:0], num_ff[56]} - {1'b0, s_ff};
      div_s   = cmd.div_start_kp ? 33'(ppp_ff) + 33'(measurement_noise) : s_ff;
      div_num = {1'b0, (cmd.div_start_kp ? ppp_ff : ppv_ff), 24'd0} + 57'(div_s >> 1);
      qfix  = (ovf_ff || (quo_ff > cvks_pkg::GAIN_ONE)) ? cvks_pkg::GAIN_ONE : quo_ff;
      kres  = (s_ff == 33'd0) ? 32'd0 : qfix[31:0];
      status.first    = first_ff;
      status.div_done = (cnt_ff == cvks_pkg::CNT_W'(cvks_pkg::DIV_STEPS));
      dec_cpp = mul_cov(kp_ff, ppp_ff);
      dec_cpv = mul_cov(kp_ff, ppv_ff);
      dec_cvv = mul_cov(kv_ff, ppv_ff);
   end

   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      vel_x_in = vel_x_ff;
      vel_y_in = vel_y_ff;
      cpp_in   = cpp_ff;
      cpv_in   = cpv_ff;
      cvv_in   = cvv_ff;
      if (cmd.init) begin
         pos_x_in = mx_ff;
         pos_y_in = my_ff;
         vel_x_in = '0;
         vel_y_in = '0;
         cpp_in   = initial_covariance;
         cpv_in   = '0;
         cvv_in   = initial_covariance;
      end else if (cmd.update) begin
         pos_x_in = sat_s32(35'(prx_ff) + 35'(dpx_ff));
         pos_y_in = sat_s32(35'(pry_ff) + 35'(dpy_ff));
         vel_x_in = sat_s32(35'(vel_x_ff) + 35'(dvx_ff));
         vel_y_in = sat_s32(35'(vel_y_ff) + 35'(dvy_ff));
         cpp_in   = ppp_ff - dec_cpp;
         cpv_in   = ppv_ff - dec_cpv;
         cvv_in   = (dec_cvv >= pvv_ff) ? 32'd0 : pvv_ff - dec_cvv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         vel_x_ff <= '0;
         vel_y_ff <= '0;
         cpp_ff   <= '0;
         cpv_ff   <= '0;
         cvv_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         vel_x_ff <= vel_x_in;
         vel_y_ff <= vel_y_in;
         cpp_ff   <= cpp_in;
         cpv_ff   <= cpv_in;
         cvv_ff   <= cvv_in;
         if (cmd.div_start_kp || cmd.div_start_kv) begin
            cnt_ff <= '0;
         end else if (cmd.div_step) begin
            cnt_ff <= cnt_ff + cvks_pkg::CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mx_ff    <= meas_x;
         my_ff    <= meas_y;
         mz_ff    <= depth_z;
         first_ff <= first_point;
      end
      if (cmd.predict) begin
         ppp_ff <= sat_u32(35'(cpp_ff) + {2'b0, cpv_ff, 1'b0} + 35'(cvv_ff)
                           + 35'(process_noise));
         ppv_ff <= sat_u32(35'(cpv_ff) + 35'(cvv_ff));
         pvv_ff <= sat_u32(35'(cvv_ff) + 35'(process_noise));
         prx_ff <= sat_s32(35'(pos_x_ff) + 35'(vel_x_ff));
         pry_ff <= sat_s32(35'(pos_y_ff) + 35'(vel_y_ff));
      end
      if (cmd.div_start_kp || cmd.div_start_kv) begin
         if (cmd.div_start_kp) begin
            s_ff <= div_s;
         end
         // seed the remainder with the upper bits; a seed at or above s overflows
         num_ff <= {div_num[32:0], 24'd0};
         rem_ff <= 34'(div_num[56:33]);
         ovf_ff <= (33'(div_num[56:33]) >= div_s);
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         if (!trial[33]) begin
            rem_ff <= trial;
         end else begin
            rem_ff <= {rem_ff[32:0], num_ff[56]};
         end
         num_ff <= {num_ff[55:0], 1'b0};
         quo_ff <= {quo_ff[31:0], ~trial[33]};
      end
      if (cmd.take_kp) begin
         kp_ff <= kres;
      end
      if (cmd.take_kv) begin
         kv_ff <= kres;
      end
      if (cmd.mul_x) begin
         dpx_ff <= mul_sgn(kp_ff, 33'(mx_ff) - 33'(prx_ff));
         dvx_ff <= mul_sgn(kv_ff, 33'(mx_ff) - 33'(prx_ff));
      end
      if (cmd.mul_y) begin
         dpy_ff <= mul_sgn(kp_ff, 33'(my_ff) - 33'(pry_ff));
         dvy_ff <= mul_sgn(kv_ff, 33'(my_ff) - 33'(pry_ff));
      end
   end

   assign est_x = pos_x_ff;
   assign est_y = pos_y_ff;
   assign out_z = mz_ff;

endmodule

>>> hw/rtl/constant_velocity_kalman_smoother_2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// constant_velocity_kalman_smoother_2d
// Constant-velocity Kalman filter on x and y of a 3D point stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one point per item: tdata = {depth_z, meas_y, meas_x},
//   tuser = first_point. A first point seeds the trajectory and gives no
//   result; every other point yields one rsp_* item {out_z, est_y, est_x}.
//   csr_* is an APB port for process_noise (0x0), measurement_noise (0x4)
//   and initial_covariance (0x8); write only while idle.
//   One item is processed at a time. A tracking point goes from acceptance
//   to rsp_tvalid through predict, two 33-step restoring divisions for
//   the gains on one shared divider, two multiply steps and an update.
//   A new point is taken only once the previous point is finished.
//   req_tready is high only when idle.
//   If the receiver stalls, the result is held and no new item is taken.
//   Reset clears the filter state to zero and the registers to defaults.
// ----------------------------------------------------------------------------
module constant_velocity_kalman_smoother_2d (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // meas_x, meas_y, depth_z
   input  logic         req_tuser,   // first_point
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,   // est_x, est_y, out_z
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   cvks_pkg::cmd_type    cmd;
   cvks_pkg::status_type status;
   logic [31:0] q_ff, r_ff, p0_ff;
   logic signed [31:0] est_x, est_y, out_z;
   logic wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff  <= 32'd1678;
         r_ff  <= 32'd1677722;
         p0_ff <= 32'd83886080;
      end else if (wr_en) begin
         case (csr_paddr[3:2])
            cvks_pkg::REG_PROCESS_NOISE:      q_ff  <= csr_pwdata;
            cvks_pkg::REG_MEASUREMENT_NOISE:  r_ff  <= csr_pwdata;
            cvks_pkg::REG_INITIAL_COVARIANCE: p0_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         cvks_pkg::REG_PROCESS_NOISE:      csr_prdata = q_ff;
         cvks_pkg::REG_MEASUREMENT_NOISE:  csr_prdata = r_ff;
         cvks_pkg::REG_INITIAL_COVARIANCE: csr_prdata = p0_ff;
         default:                          csr_prdata = 32'd0;
      endcase
   end

   cvks_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   cvks_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .process_noise      (q_ff),
      .measurement_noise  (r_ff),
      .initial_covariance (p0_ff),
      .meas_x             (req_tdata[31:0]),
      .meas_y             (req_tdata[63:32]),
      .depth_z            (req_tdata[95:64]),
      .first_point        (req_tuser),
      .est_x              (est_x),
      .est_y              (est_y),
      .out_z              (out_z)
   );

   assign rsp_tdata = {out_z, est_y, est_x};

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("input taken while result pending");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped under stall");

   a_first_no_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> ##1 !rsp_tvalid)
      else $error("first point produced a result");

endmodule

>>> tb/sv/constant_velocity_kalman_smoother_2d_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// constant_velocity_kalman_smoother_2d_test
// Self-checking bench for the 2D constant-velocity smoother: directed table,
// then random trajectories under random idling and csr settings, each result
// compared against an in-bench filter model.
// ----------------------------------------------------------------------------
module constant_velocity_kalman_smoother_2d_test;

   localparam int LIMIT_CYCLES = 1000000;
   localparam logic [31:0] GAIN_UNIT = 32'h0100_0000;

   typedef struct packed {
      logic signed [31:0] z;
      logic signed [31:0] y;
      logic signed [31:0] x;
   } point_type;

   typedef struct {
      point_type pt;
      logic      first;
      logic      has_exp;
      point_type exp_pt;
   } row_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [95:0]  req_tdata = '0;
   logic         req_tuser = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [95:0]  rsp_tdata;
   logic         csr_psel = 0;
   logic         csr_penable = 0;
   logic         csr_pwrite = 0;
   logic [3:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   constant_velocity_kalman_smoother_2d dut (.*);

   always #5 clock = ~clock;

   logic [31:0] q_noise, r_noise, p_init;
   logic signed [31:0] px, py, vx, vy;
   logic [31:0] cpp, cpv, cvv;
   point_type estimates[$];
   int errors = 0, n_results = 0, n_items = 0;
   int cycles = 0;
   bit rx_calm = 0;
   int rx_gap = 0;
   bit hold_go = 0, hold_seen = 0;
   int hold_cnt = 0;

   function automatic logic signed [31:0] sat_s(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic logic [31:0] sat_u(logic [63:0] v);
      return v > 64'hffff_ffff ? 32'hffff_ffff : v[31:0];
   endfunction

   function automatic logic [63:0] scale_cov(logic [31:0] k, logic [31:0] c);
      return ({32'd0, k} * {32'd0, c} + 64'h80_0000) >> 24;
   endfunction

   function automatic logic signed [63:0] scale_err(logic [31:0] k,
                                                   logic signed [63:0] e);
      logic [63:0] mag, r;
      mag = e < 0 ? -e : e;
      r = ({32'd0, k} * mag + 64'h80_0000) >> 24;
      return e < 0 ? -$signed(r) : $signed(r);
   endfunction

   function automatic logic [31:0] gain_of(logic [31:0] num, logic [63:0] s);
      logic [63:0] k;
      if (s == 0) return 0;
      k = (({32'd0, num} << 24) + (s >> 1)) / s;
      return k > GAIN_UNIT ? GAIN_UNIT : k[31:0];
   endfunction

   task automatic track_axis(inout logic signed [31:0] p, inout logic signed [31:0] v,
                             input logic signed [31:0] m, input logic [31:0] kp,
                             input logic [31:0] kv);
      logic signed [63:0] pred, e;
      pred = sat_s(64'(p) + 64'(v));
      e = 64'(m) - pred;
      p = sat_s(pred + scale_err(kp, e));
      v = sat_s(64'(v) + scale_err(kv, e));
   endtask

   task automatic filter_point(input point_type pt, input logic first);
      logic [31:0] ppp, ppv, pvv, kp, kv;
      logic [63:0] s, dec;
      point_type o;
      if (first) begin
         px = pt.x; py = pt.y; vx = 0; vy = 0;
         cpp = p_init; cpv = 0; cvv = p_init;
         return;
      end
      ppp = sat_u(64'(cpp) + 2 * 64'(cpv) + 64'(cvv) + 64'(q_noise));
      ppv = sat_u(64'(cpv) + 64'(cvv));
      pvv = sat_u(64'(cvv) + 64'(q_noise));
      s = 64'(ppp) + 64'(r_noise);
      kp = gain_of(ppp, s);
      kv = gain_of(ppv, s);
      track_axis(px, vx, pt.x, kp, kv);
      track_axis(py, vy, pt.y, kp, kv);
      cpp = ppp - 32'(scale_cov(kp, ppp));
      cpv = ppv - 32'(scale_cov(kp, ppv));
      dec = scale_cov(kv, ppv);
      cvv = dec >= 64'(pvv) ? 0 : pvv - 32'(dec);
      o.x = px; o.y = py; o.z = pt.z;
      estimates = {estimates, o};
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout at %0t", $time);
         $display("FAIL");
         $finish;
      end
   end

   // long receiver hold, counted here
   always @(posedge clock) begin
      if (hold_go != hold_seen) begin
         hold_seen <= hold_go;
         hold_cnt  <= 400;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
      end
   end

   // receiver: random stalls, long hold on request, none near the end
   always @(posedge clock) begin
      point_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         n_results++;
         if (estimates.size() == 0) begin
            errors++;
            $display("%0t unexpected result %h", $time, got);
         end else begin
            want = estimates.pop_front();
            if (got.x !== want.x) begin
               errors++;
               $display("%0t est_x exp %h got %h", $time, want.x, got.x);
            end
            if (got.y !== want.y) begin
               errors++;
               $display("%0t est_y exp %h got %h", $time, want.y, got.y);
            end
            if (got.z !== want.z) begin
               errors++;
               $display("%0t out_z exp %h got %h", $time, want.z, got.z);
            end
         end
      end
      if (hold_cnt > 0) rsp_tready <= 0;
      else if (rx_calm) rsp_tready <= 1;
      else if (rx_gap > 0) begin
         rsp_tready <= 0;
         rx_gap <= rx_gap - 1;
      end else if ($urandom_range(0, 15) == 0) begin
         rx_gap <= $urandom_range(0, 17);
         rsp_tready <= 0;
      end else rsp_tready <= 1;
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      case (idx)
         cvks_pkg::REG_PROCESS_NOISE:      q_noise = val;
         cvks_pkg::REG_MEASUREMENT_NOISE:  r_noise = val;
         cvks_pkg::REG_INITIAL_COVARIANCE: p_init = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_point(input point_type pt, input logic first, input bit gaps);
      int gap;
      if (gaps && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 18);
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1; req_tdata <= pt; req_tuser <= first;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      filter_point(pt, first);
      n_items++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (estimates.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_coord(input int mode);
      case (mode)
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 2000000))) - 32'sd1000000;
         default: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      endcase
   endfunction

   task automatic random_run(input int count, input bit gaps);
      point_type pt, base;
      int mode, len;
      while (count > 0) begin
         mode = $urandom_range(0, 9) == 0 ? 0 : ($urandom_range(0, 19) == 0 ? 2 : 1);
         base.x = rand_coord(mode); base.y = rand_coord(mode); base.z = $urandom;
         send_point(base, $urandom_range(0, 9) != 0, gaps);
         count--;
         len = $urandom_range(2, 30);
         for (int i = 0; i < len && count > 0; i++) begin
            pt.x = $urandom_range(0, 15) == 0 ? rand_coord(0) :
                   sat_s(64'(base.x) + 64'(i * 32'sd65536) + $signed($urandom_range(0, 60000)));
            pt.y = $urandom_range(0, 15) == 0 ? rand_coord(0) :
                   sat_s(64'(base.y) - 64'(i * 32'sd30000) + $signed($urandom_range(0, 60000)));
            pt.z = $urandom;
            send_point(pt, $urandom_range(0, 40) == 0, gaps);
            count--;
         end
      end
   endtask

   row_type table_rows[$];

   task automatic add_row(input logic signed [31:0] x, input logic signed [31:0] y,
                          input logic signed [31:0] z, input logic first,
                          input logic has_exp, input point_type ex);
      row_type r;
      r.pt.x = x; r.pt.y = y; r.pt.z = z; r.first = first;
      r.has_exp = has_exp; r.exp_pt = ex;
      table_rows = {table_rows, r};
   endtask

   initial begin
      point_type zero_pt, ex;
      zero_pt = '0;
      q_noise = 1678; r_noise = 1677722; p_init = 83886080;
      px = 0; py = 0; vx = 0; vy = 0; cpp = 0; cpv = 0; cvv = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // from reset with zero covariance the gain is tiny, so zero in zero out
      ex = '0; ex.z = 32'h1234_5678;
      add_row(0, 0, 32'h1234_5678, 0, 1, ex);
      add_row(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 0, 0, zero_pt);
      add_row(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1, 0, zero_pt);
      add_row(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 0, 0, zero_pt);
      add_row(32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, zero_pt);
      add_row(32'h0001_0000, 32'hffff_0000, 5, 1, 0, zero_pt);
      for (int i = 2; i < 10; i++)
         add_row(i * 32'h0001_0000, -i * 32'h0001_0000, i, 0, 0, zero_pt);
      add_row(32'h7fff_0000, 32'h7fff_0000, 1, 0, 0, zero_pt);
      add_row(32'h7fff_ffff, 32'h7fff_ffff, 2, 0, 0, zero_pt);
      add_row(32'h8000_0000, 32'h8000_0000, 3, 0, 0, zero_pt);
      foreach (table_rows[i]) begin
         if (table_rows[i].has_exp && !table_rows[i].first) begin
            send_point(table_rows[i].pt, 0, 0);
            void'(estimates.pop_back());
            estimates = {estimates, table_rows[i].exp_pt};
            // keep model in step with the typed value
         end else send_point(table_rows[i].pt, table_rows[i].first, 0);
      end
      drain();

      // extremes: zero process noise, huge covariance; then all-ones noise, zero covariance
      csr_write(cvks_pkg::REG_PROCESS_NOISE, 0);
      csr_write(cvks_pkg::REG_MEASUREMENT_NOISE, 1);
      csr_write(cvks_pkg::REG_INITIAL_COVARIANCE, 32'hffff_ffff);
      random_run(120, 1);
      drain();
      csr_write(cvks_pkg::REG_PROCESS_NOISE, 32'hffff_ffff);
      csr_write(cvks_pkg::REG_MEASUREMENT_NOISE, 32'hffff_ffff);
      csr_write(cvks_pkg::REG_INITIAL_COVARIANCE, 0);
      random_run(120, 1);
      drain();
      csr_write(cvks_pkg::REG_PROCESS_NOISE, 1678);
      csr_write(cvks_pkg::REG_MEASUREMENT_NOISE, 1677722);
      csr_write(cvks_pkg::REG_INITIAL_COVARIANCE, 83886080);
      hold_go = ~hold_go;
      random_run(200, 1);
      drain();
      for (int ph = 0; ph < 6; ph++) begin
         csr_write(cvks_pkg::REG_PROCESS_NOISE,
                   $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 20));
         csr_write(cvks_pkg::REG_MEASUREMENT_NOISE, $urandom_range(1, 1 << 26));
         csr_write(cvks_pkg::REG_INITIAL_COVARIANCE,
                   $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 28));
         random_run(200, 1);
         drain();
      end
      rx_calm = 1;
      random_run(240, 0);
      drain();

      $display("Ran %0d points, %0d estimates checked across %0d noise settings.",
               n_items, n_results, 10);
      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
